### rtl/c8rp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c8rp_pkg;

  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 8;
  localparam int LEFT_W    = 7;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_DRAW16 = 3'd0,
    CMD_DRAW32 = 3'd1,
    CMD_DRAW64 = 3'd2,
    CMD_REKEY  = 3'd3,
    CMD_INIT   = 3'd4,
    CMD_FORK   = 3'd5
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_01 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_23 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_45 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_67 = 8'd3;

  localparam logic [LEFT_W-1:0] POOL_BYTES = 7'd64;

  // "expand 32-byte k", word 0 in the low slot
  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef logic [15:0][WORD_W-1:0] blk_words_t;

  typedef struct packed {
    logic [7:0][WORD_W-1:0] key;
    logic [63:0]            counter;
    logic [1:0][WORD_W-1:0] nonce;
  } blk_in_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

`default_nettype wire

### rtl/c8rp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface c8rp_in_if;
  import c8rp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [31:0]       time_nonce;
  logic [31:0]       proc_nonce;
  logic [63:0]       entropy_lo;
  logic [63:0]       entropy_hi;
  modport source (output valid, cmd, time_nonce, proc_nonce, entropy_lo, entropy_hi,
                  input ready);
  modport sink (input valid, cmd, time_nonce, proc_nonce, entropy_lo, entropy_hi,
                output ready);
endinterface

interface c8rp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        initialized;
  modport source (output valid, value, initialized, input ready);
  modport sink (input valid, value, initialized, output ready);
endinterface

interface c8rp_cfg_if;
  import c8rp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/c8rp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module c8rp_core #(
  parameter int DOUBLE_ROUNDS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire c8rp_pkg::blk_in_t    blk_in,
  output logic                      done,
  output c8rp_pkg::blk_words_t      block
);
  import c8rp_pkg::*;

  localparam int STEPS = 8 * DOUBLE_ROUNDS;
  localparam int SCW   = $clog2(STEPS);
  localparam logic [SCW-1:0] LAST_STEP = SCW'(STEPS - 1);

  // quarter-round split into four add/xor/rotate steps
  localparam logic [1:0] SUB_A_D16 = 2'd0;
  localparam logic [1:0] SUB_C_B12 = 2'd1;
  localparam logic [1:0] SUB_A_D8  = 2'd2;
  localparam logic [1:0] SUB_C_B7  = 2'd3;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_t;

  cstate_t     state_r;
  logic [SCW-1:0] step_cnt_r;
  blk_words_t  x_r;
  blk_words_t  x_nxt;
  blk_words_t  init_w;

  logic        dg;
  logic [1:0]  sub;
  logic [1:0]  ln;
  logic [3:0]  ia, ib, ic, id;
  word_t       sum;

  always_comb begin
    init_w[3:0]   = SIGMA;
    init_w[11:4]  = blk_in.key;
    init_w[12]    = blk_in.counter[31:0];
    init_w[13]    = blk_in.counter[63:32];
    init_w[15:14] = blk_in.nonce;
  end

  // four lanes, one step each per cycle; dg selects column or diagonal pass
  always_comb begin
    x_nxt = x_r;
    dg    = step_cnt_r[2];
    sub   = step_cnt_r[1:0];
    ln    = '0;
    ia    = '0;
    ib    = '0;
    ic    = '0;
    id    = '0;
    sum   = '0;
    for (int l = 0; l < 4; l++) begin
      ln = 2'(l);
      ia = {2'b00, ln};
      ib = {2'b01, ln + {1'b0, dg}};
      ic = {2'b10, ln + {dg, 1'b0}};
      id = {2'b11, ln + {dg, dg}};
      case (sub)
        SUB_A_D16: begin
          sum       = x_r[ia] + x_r[ib];
          x_nxt[ia] = sum;
          x_nxt[id] = rotl(x_r[id] ^ sum, 16);
        end
        SUB_C_B12: begin
          sum       = x_r[ic] + x_r[id];
          x_nxt[ic] = sum;
          x_nxt[ib] = rotl(x_r[ib] ^ sum, 12);
        end
        SUB_A_D8: begin
          sum       = x_r[ia] + x_r[ib];
          x_nxt[ia] = sum;
          x_nxt[id] = rotl(x_r[id] ^ sum, 8);
        end
        SUB_C_B7: begin
          sum       = x_r[ic] + x_r[id];
          x_nxt[ic] = sum;
          x_nxt[ib] = rotl(x_r[ib] ^ sum, 7);
        end
        default: begin
          sum = '0;
        end
      endcase
    end
  end

  // feed-forward; inputs are held steady by the caller throughout
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      block[i] = x_r[i] + init_w[i];
    end
  end

  assign done = (state_r == C_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= C_IDLE;
      step_cnt_r <= '0;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (start) begin
            x_r        <= init_w;
            step_cnt_r <= '0;
            state_r    <= C_RUN;
          end
        end
        C_RUN: begin
          x_r        <= x_nxt;
          step_cnt_r <= step_cnt_r + 1'b1;
          if (step_cnt_r == LAST_STEP) begin
            state_r <= C_DONE;
          end
        end
        C_DONE: begin
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/chacha8_random_pool_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ChaCha keystream random pool.
// in_chan: one command per request (draw16/32/64, rekey, init, fork) with its
//   nonce and entropy operands. Ready only while the sequencer is idle.
// out_chan: exactly one result per command: the drawn value (zero for
//   non-draw commands) and the initialised flag (nonce word 15 nonzero).
// cfg_chan: key words for init, index 0..3; always ready. Other indexes
//   are dropped. Write only while no command is in flight.
// A draw served from the pool passes S_EXEC, S_DRAW_CHK, S_DRAW_TAKE and
//   S_FINISH on its way to the result. Each new keystream block is made by
//   the single four-lane quarter-round step unit in c8rp_core; init makes
//   one block, rekey one or two, fork two.
// Throughput: one command at a time; a 64-byte block feeds up to 32 draws.
// The result sits in an output register; the next command is accepted while
//   it waits, and a stalled receiver holds that command's result back.
// Reset (synchronous, active low) clears key, counter, nonces, pool and key
//   registers; draws before init use the all-zero key.

module chacha8_random_pool_unit #(
  parameter int DOUBLE_ROUNDS = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  c8rp_in_if.sink     in_chan,
  c8rp_out_if.source  out_chan,
  c8rp_cfg_if.sink    cfg_chan
);
  import c8rp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DRAW_CHK, S_DRAW_TAKE, S_REKEY_CHK, S_REKEY_XOR,
    S_BLK, S_BLK_GO, S_BLK_WAIT, S_FINISH
  } state_t;

  state_t                  state_r;
  state_t                  ret_r;
  cmd_t                    cmd_r;
  logic [31:0]             tn_r;
  logic [31:0]             pn_r;
  logic [63:0]             elo_r;
  logic [63:0]             ehi_r;
  logic [63:0]             value_r;

  logic [3:0][63:0]        cfg_key_r;
  logic [7:0][WORD_W-1:0]  key_r;
  logic [63:0]             counter_r;
  logic [1:0][WORD_W-1:0]  nonce_r;
  blk_words_t              ks_r;
  logic [LEFT_W-1:0]       left_r;

  logic                    out_valid_r;
  logic [63:0]             out_value_r;
  logic                    out_init_r;

  blk_in_t                 blk_in;
  blk_words_t              core_block;
  logic                    core_done;
  logic                    core_start;

  logic [3:0]              draw_bytes;
  logic [LEFT_W-1:0]       left_take;
  logic [5:0]              off;
  logic [7:0][63:0]        ks_pair;
  logic [63:0]             pair;
  word_t                   word;
  logic [63:0]             draw_val;

  assign blk_in.key     = key_r;
  assign blk_in.counter = counter_r;
  assign blk_in.nonce   = nonce_r;
  assign core_start     = (state_r == S_BLK_GO);

  c8rp_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (core_start),
    .blk_in (blk_in),
    .done   (core_done),
    .block  (core_block)
  );

  // draws are taken from the top of the block downwards
  always_comb begin
    case (cmd_r)
      CMD_DRAW16: draw_bytes = 4'd2;
      CMD_DRAW32: draw_bytes = 4'd4;
      CMD_DRAW64: draw_bytes = 4'd8;
      default:    draw_bytes = 4'd2;
    endcase
    left_take = left_r - LEFT_W'(draw_bytes);
    off       = left_take[5:0];
    ks_pair   = ks_r;
    pair      = ks_pair[off[5:3]];
    word      = off[2] ? pair[63:32] : pair[31:0];
    case (cmd_r)
      CMD_DRAW64: draw_val = pair;
      CMD_DRAW32: draw_val = {32'd0, word};
      default:    draw_val = {48'd0, (off[1] ? word[31:16] : word[15:0])};
    endcase
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.value       = out_value_r;
  assign out_chan.initialized = out_init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cfg_key_r   <= '0;
      key_r       <= '0;
      counter_r   <= '0;
      nonce_r     <= '0;
      ks_r        <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          CFG_KEY_01: cfg_key_r[0] <= cfg_chan.data;
          CFG_KEY_23: cfg_key_r[1] <= cfg_chan.data;
          CFG_KEY_45: cfg_key_r[2] <= cfg_chan.data;
          CFG_KEY_67: cfg_key_r[3] <= cfg_chan.data;
          default: ;
        endcase
      end

      // S_FINISH owns the valid flag while it is loading a new result
      if (out_chan.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            cmd_r   <= cmd_t'(in_chan.cmd);
            tn_r    <= in_chan.time_nonce;
            pn_r    <= in_chan.proc_nonce;
            elo_r   <= in_chan.entropy_lo;
            ehi_r   <= in_chan.entropy_hi;
            value_r <= '0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_r)
            CMD_DRAW16, CMD_DRAW32, CMD_DRAW64: begin
              left_r  <= left_r & ~LEFT_W'(draw_bytes - 4'd1);
              state_r <= S_DRAW_CHK;
            end
            CMD_REKEY: begin
              state_r <= S_REKEY_CHK;
            end
            CMD_INIT: begin
              // packed layout puts the lower-numbered word in the low half
              key_r     <= cfg_key_r;
              counter_r <= '0;
              nonce_r   <= {pn_r, tn_r};
              ret_r     <= S_FINISH;
              state_r   <= S_BLK;
            end
            CMD_FORK: begin
              key_r[0]   <= key_r[0] ^ elo_r[31:0];
              key_r[1]   <= key_r[1] ^ elo_r[63:32];
              key_r[2]   <= key_r[2] ^ ehi_r[31:0];
              key_r[3]   <= key_r[3] ^ ehi_r[63:32];
              nonce_r[1] <= pn_r;
              ret_r      <= S_REKEY_CHK;
              state_r    <= S_BLK;
            end
            default: begin
              state_r <= S_FINISH;
            end
          endcase
        end
        S_DRAW_CHK: begin
          if (left_r == '0) begin
            ret_r   <= S_DRAW_TAKE;
            state_r <= S_BLK;
          end else begin
            state_r <= S_DRAW_TAKE;
          end
        end
        S_DRAW_TAKE: begin
          left_r  <= left_take;
          value_r <= draw_val;
          state_r <= S_FINISH;
        end
        S_REKEY_CHK: begin
          // fewer than 32 bytes left: need a fresh block for the key material
          if (left_r[6:5] == 2'b00) begin
            ret_r   <= S_REKEY_XOR;
            state_r <= S_BLK;
          end else begin
            state_r <= S_REKEY_XOR;
          end
        end
        S_REKEY_XOR: begin
          key_r      <= key_r ^ ks_r[7:0];
          nonce_r[0] <= tn_r;
          ret_r      <= S_FINISH;
          state_r    <= S_BLK;
        end
        S_BLK: begin
          counter_r <= counter_r + 64'd1;
          state_r   <= S_BLK_GO;
        end
        S_BLK_GO: begin
          state_r <= S_BLK_WAIT;
        end
        S_BLK_WAIT: begin
          if (core_done) begin
            ks_r    <= core_block;
            left_r  <= POOL_BYTES;
            state_r <= ret_r;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= value_r;
            out_init_r  <= (nonce_r[1] != '0);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
